@@ rtl/ps2mct_pkg.sv @@
// Package for the PS/2 mouse packet cursor tracker.
// Holds the field widths, register indexes, packet bit positions and the result type.
// No dependencies.
`default_nettype none

package ps2mct_pkg;

    localparam int COORD_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W     = COORD_W + 2;   // signed candidate coordinate

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 1'd1;

    localparam logic [COORD_W-1:0] X_LIMIT_RESET = 11'd1023;
    localparam logic [COORD_W-1:0] Y_LIMIT_RESET = 11'd767;

    // Bit positions within the first byte of a packet.
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_SYNC   = 3;
    localparam int BIT_X_SIGN = 4;
    localparam int BIT_Y_SIGN = 5;
    localparam int BIT_X_OVF  = 6;
    localparam int BIT_Y_OVF  = 7;

    // Position within the open packet.
    localparam logic [1:0] CNT_IDLE   = 2'd0;
    localparam logic [1:0] CNT_FIRST  = 2'd1;
    localparam logic [1:0] CNT_SECOND = 2'd2;

    typedef struct packed {
        logic               left_btn;
        logic               right_btn;
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic               moved;
        logic               overflowed;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/ps2_mouse_packet_cursor_tracker_core.sv @@
// Top level of the PS/2 mouse packet cursor tracker.
// Decodes three-byte mouse packets and keeps a bounded cursor; uses ps2mct_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall, rx_byte, rx_error) takes one mouse byte
//   per request. Bytes with rx_error set are dropped. A packet opens on a byte
//   with bit 3 set and closes on its third byte, which produces one result on
//   the output channel (out_valid / out_stall) carrying the buttons, the cursor
//   after the move, and the moved and overflowed flags. Other bytes produce none.
//   Configuration writes (cfg_we, cfg_index, cfg_data) set x_limit and y_limit
//   and must be made only while the block is idle; the block does not enforce it.
//
//   Throughput is one byte per cycle while no closing byte is held back by a
//   stalled output. A byte is captured in an input register, then decoded and
//   applied to the cursor, and its result is registered in the output register;
//   out_valid rises when the closing byte leaves the input register.
//   When the receiver stalls, the output register holds its result; the input
//   stage keeps taking bytes until it holds a closing byte that cannot move on.
//   Reset clears the packet position and the cursor to zero and sets the limits
//   to 1023 and 767.
`default_nettype none

module ps2_mouse_packet_cursor_tracker_core
    import ps2mct_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 rx_error,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      left_btn,
    output logic                      right_btn,
    output logic [COORD_W-1:0]        cursor_x,
    output logic [COORD_W-1:0]        cursor_y,
    output logic                      moved,
    output logic                      overflowed,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data
);

    logic [COORD_W-1:0] x_limit_reg;
    logic [COORD_W-1:0] y_limit_reg;

    // Input register.
    logic               in_vld_reg;
    logic [7:0]         in_byte_reg;
    logic               in_err_reg;

    // Packet state.
    logic [1:0]         byte_count_reg, byte_count_next;
    logic [7:0]         first_byte_reg, first_byte_next;
    logic [7:0]         second_byte_reg, second_byte_next;
    logic [COORD_W-1:0] cur_x_reg, cur_x_next;
    logic [COORD_W-1:0] cur_y_reg, cur_y_next;

    // Output register.
    logic               out_vld_reg;
    result_t            result_reg, result_next;

    logic               closes_packet;
    logic               out_free;
    logic               advance;
    logic signed [POS_W-1:0] dx, dy, nx, ny;
    logic               in_bounds;
    logic               ovf;

    assign closes_packet = in_vld_reg && !in_err_reg && (byte_count_reg == CNT_SECOND);
    assign out_free      = !out_vld_reg || !out_stall;
    assign advance       = in_vld_reg && (!closes_packet || out_free);
    assign in_stall      = in_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RESET;
            y_limit_reg <= Y_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_X_LIMIT: x_limit_reg <= cfg_data;
                CFG_Y_LIMIT: y_limit_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
            in_err_reg  <= rx_error;
        end
    end

    // The deltas are 9-bit two's complement: sign bit from the first byte.
    assign dx = {{(POS_W-9){first_byte_reg[BIT_X_SIGN]}}, first_byte_reg[BIT_X_SIGN],
                 second_byte_reg};
    assign dy = {{(POS_W-9){first_byte_reg[BIT_Y_SIGN]}}, first_byte_reg[BIT_Y_SIGN],
                 in_byte_reg};
    assign nx = $signed({2'b00, cur_x_reg}) + dx;
    assign ny = $signed({2'b00, cur_y_reg}) - dy;
    assign ovf = first_byte_reg[BIT_X_OVF] || first_byte_reg[BIT_Y_OVF];
    assign in_bounds = !nx[POS_W-1] && (nx[COORD_W-1:0] <= x_limit_reg) && !nx[COORD_W]
                    && !ny[POS_W-1] && (ny[COORD_W-1:0] <= y_limit_reg) && !ny[COORD_W];

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        result_next      = result_reg;

        if (advance && !in_err_reg)
        begin
            case (byte_count_reg)
                CNT_IDLE:
                begin
                    if (in_byte_reg[BIT_SYNC])
                    begin
                        first_byte_next = in_byte_reg;
                        byte_count_next = CNT_FIRST;
                    end
                end
                CNT_FIRST:
                begin
                    second_byte_next = in_byte_reg;
                    byte_count_next  = CNT_SECOND;
                end
                CNT_SECOND:
                begin
                    byte_count_next = CNT_IDLE;
                    if (!ovf && in_bounds)
                    begin
                        cur_x_next = nx[COORD_W-1:0];
                        cur_y_next = ny[COORD_W-1:0];
                    end
                    result_next.left_btn     = first_byte_reg[BIT_LEFT];
                    result_next.right_btn    = first_byte_reg[BIT_RIGHT];
                    result_next.cursor_x     = (!ovf && in_bounds) ? nx[COORD_W-1:0]
                                                                   : cur_x_reg;
                    result_next.cursor_y     = (!ovf && in_bounds) ? ny[COORD_W-1:0]
                                                                   : cur_y_reg;
                    result_next.moved        = !ovf && in_bounds;
                    result_next.overflowed   = ovf;
                end
                default:
                begin
                    byte_count_next = CNT_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= CNT_IDLE;
            first_byte_reg  <= '0;
            second_byte_reg <= '0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            if (advance && closes_packet)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid    = out_vld_reg;
    assign left_btn     = result_reg.left_btn;
    assign right_btn    = result_reg.right_btn;
    assign cursor_x     = result_reg.cursor_x;
    assign cursor_y     = result_reg.cursor_y;
    assign moved        = result_reg.moved;
    assign overflowed   = result_reg.overflowed;

endmodule

`default_nettype wire
